// ===== src/glc_pkg.sv =====
// Shared types and constants for the grid line-of-sight checker.
// No dependencies; every other file imports this package.
`default_nettype none

package glc_pkg;

  localparam int MAP_ROWS     = 64;
  localparam int MAP_COLS     = 64;
  localparam int TERRAIN_BITS = 16;
  localparam int MAP_DEPTH    = MAP_ROWS * MAP_COLS;
  localparam int ADDR_W       = $clog2(MAP_DEPTH);

  // Signed walk coordinates, wide enough for steps that leave the grid.
  localparam int COORD_W = 10;
  // Slope numerators and denominators, the column index and the row offset.
  localparam int P_W     = 8;
  localparam int V_W     = 8;
  localparam int MUL_A_W = V_W + 1;
  localparam int MUL_Y_W = MUL_A_W + P_W;
  // Divider operand widths.
  localparam int DIV_NUM_W = 16;
  localparam int DIV_DEN_W = P_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [1:0]         step_t;

  typedef struct packed {
    logic        action;
    logic [5:0]  row_a;
    logic [5:0]  col_a;
    logic [15:0] terrain_bits;
    logic [5:0]  target_row;
    logic [5:0]  target_col;
    logic [5:0]  sight_radius;
    logic [15:0] pass_mask;
  } glc_in_t;

  typedef struct packed {
    logic is_query_result;
    logic line_clear;
  } glc_out_t;

endpackage

`default_nettype wire

// ===== src/glc_ifs.sv =====
// Valid/ready channel interfaces for the request and result words.
// Depends on glc_pkg for the payload types.
`default_nettype none

interface glc_in_if import glc_pkg::*; ();
  logic    valid;
  logic    ready;
  glc_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface glc_out_if import glc_pkg::*; ();
  logic     valid;
  logic     ready;
  glc_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/glc_div.sv =====
// Restoring divider, one quotient bit per cycle, used for the first row
// offset of each column. Depends on glc_pkg for operand widths.
`default_nettype none

module glc_div import glc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DIV_NUM_W-1:0] dividend_i,
  input  wire logic [DIV_DEN_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [DIV_NUM_W-1:0]      quotient_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_sub;
  logic                 ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[DIV_NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
      rem_q <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== src/grid_line_of_sight_check.sv =====
// Grid line-of-sight checker: top level with tile memory and query sequencer.
// Depends on glc_pkg, glc_ifs (channel interfaces) and glc_div.
`default_nettype none

// After reset the block sweeps the 4096-entry terrain memory to zero, one tile
// per cycle, and takes no word until the sweep is done. A tile write is stored
// as the word is taken. A query that ends early goes from idle straight to the
// done state when the target is the viewer tile or out of range, and through the
// viewer check state first when the viewer tile is blocked. Otherwise it walks
// the octant column by column: each column starts with one multiply and the
// 16-step divider, then for each tile probed one memory read, the tile decision
// and two slope multiplies on the single shared multiplier, and closes with the
// end-of-column slope checks. The block accepts no new word while a query is in
// progress.
module grid_line_of_sight_check import glc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  glc_in_if.sink     in_i,
  glc_out_if.source  out_o
);

  typedef enum logic [12:0] {
    ST_CLEAR = 13'h0001,
    ST_IDLE  = 13'h0002,
    ST_VCHK  = 13'h0004,
    ST_MUL0  = 13'h0008,
    ST_DIVS  = 13'h0010,
    ST_DIVW  = 13'h0020,
    ST_RD    = 13'h0040,
    ST_TILE  = 13'h0080,
    ST_CMPA  = 13'h0100,
    ST_CMPB  = 13'h0200,
    ST_ENDA  = 13'h0400,
    ST_ENDB  = 13'h0800,
    ST_DONE  = 13'h1000
  } state_e;

  function automatic coord_t scale(step_t s, logic [V_W-1:0] x);
    coord_t xe;
    xe = coord_t'({2'b00, x});
    case (s)
      2'sb01:  scale = xe;
      2'sb11:  scale = -xe;
      default: scale = '0;
    endcase
  endfunction

  function automatic step_t sign_mul(step_t a, step_t b);
    step_t p;
    p = '0;
    if (a != 2'sb00 && b != 2'sb00) begin
      p = (a == b) ? 2'sb01 : 2'sb11;
    end
    return p;
  endfunction

  state_e state_q, state_d;
  logic   res_q, res_d;

  logic              out_valid_q;
  glc_out_t          out_q;
  logic [ADDR_W-1:0] clr_q;

  logic [5:0]  cr_q, cc_q, adr_q, adc_q, maxd_q, u_q;
  logic        drn_q, dcn_q;
  logic [15:0] pm_q;
  logic [P_W-1:0] p1_q, q1_q, p2_q, q2_q;
  step_t       ru_q, cu_q, rv_q, cv_q;
  logic [V_W-1:0]     v_q;
  logic               space_q, block_q;
  logic [MUL_Y_W-1:0] prod_q;

  logic [TERRAIN_BITS-1:0] mem [MAP_DEPTH];
  logic [TERRAIN_BITS-1:0] rdata_q;
  logic                    ok_q;

  glc_in_t pl;
  logic    in_fire, out_fire, load_out;

  assign pl       = in_i.payload;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);

  // Early tests on the incoming query.
  logic signed [6:0] dr_in, dc_in;
  logic [5:0] adr_in, adc_in;
  logic       same_in, far_in;

  always_comb begin
    dr_in   = $signed({1'b0, pl.target_row}) - $signed({1'b0, pl.row_a});
    dc_in   = $signed({1'b0, pl.target_col}) - $signed({1'b0, pl.col_a});
    adr_in  = dr_in[6] ? 6'(-dr_in) : dr_in[5:0];
    adc_in  = dc_in[6] ? 6'(-dc_in) : dc_in[5:0];
    same_in = (pl.row_a == pl.target_row) && (pl.col_a == pl.target_col);
    far_in  = (adr_in > pl.sight_radius) || (adc_in > pl.sight_radius);
  end

  // Octant setup, used in the viewer check state.
  logic [5:0]     su_maxd, su_mind;
  logic [P_W-1:0] su_p1, su_q1, su_p2, su_q2;
  step_t          su_dr, su_dc, su_dr_m, su_dc_m, su_or;

  always_comb begin
    su_dr = drn_q ? 2'sb11 : 2'sb01;
    su_dc = dcn_q ? 2'sb11 : 2'sb01;
    if (adr_q == adc_q) begin
      su_or   = 2'sb01;
      su_dr_m = (drn_q == dcn_q) ? su_dr : 2'sb00;
      su_dc_m = (drn_q == dcn_q) ? 2'sb00 : su_dc;
      su_maxd = adr_q;
      su_mind = adr_q;
    end else if (adr_q > adc_q) begin
      su_or   = (drn_q ^ dcn_q) ? 2'sb11 : 2'sb01;
      su_dr_m = su_dr;
      su_dc_m = 2'sb00;
      su_maxd = adr_q;
      su_mind = adc_q;
    end else begin
      su_or   = (drn_q ^ dcn_q) ? 2'sb01 : 2'sb11;
      su_dr_m = 2'sb00;
      su_dc_m = su_dc;
      su_maxd = adc_q;
      su_mind = adr_q;
    end
    if (adr_q == adc_q) begin
      su_p1 = P_W'(1);
      su_q1 = P_W'(1);
      su_p2 = P_W'(1);
      su_q2 = P_W'(1);
    end else if (su_mind == '0) begin
      su_p1 = '0;
      su_q1 = P_W'(1);
      su_p2 = '0;
      su_q2 = P_W'(1);
    end else begin
      su_p1 = {1'b0, su_mind, 1'b0} - P_W'(1);
      su_q1 = {1'b0, su_maxd, 1'b1};
      su_p2 = {1'b0, su_mind, 1'b1};
      su_q2 = {1'b0, su_maxd, 1'b0} - P_W'(1);
    end
  end

  // The one shared multiplier.
  logic [MUL_A_W-1:0] mul_a;
  logic [P_W-1:0]     mul_b, two_u_m1, two_u_p1;
  logic [MUL_Y_W-1:0] mul_y;

  assign two_u_m1 = {1'b0, u_q, 1'b0} - P_W'(1);
  assign two_u_p1 = {1'b0, u_q, 1'b1};

  always_comb begin
    case (state_q)
      ST_MUL0: begin mul_a = MUL_A_W'(p1_q); mul_b = two_u_m1; end
      ST_CMPA: begin mul_a = {v_q, 1'b1};    mul_b = q2_q;     end
      ST_CMPB: begin mul_a = MUL_A_W'(p2_q); mul_b = two_u_p1; end
      ST_ENDA: begin mul_a = MUL_A_W'(p1_q); mul_b = q2_q;     end
      ST_ENDB: begin mul_a = MUL_A_W'(p2_q); mul_b = q1_q;     end
      default: begin mul_a = '0;             mul_b = '0;       end
    endcase
    mul_y = MUL_Y_W'(mul_a) * MUL_Y_W'(mul_b);
  end

  // Divider for the first row offset of each column.
  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_quo;

  assign div_start = (state_q == ST_DIVS);

  glc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DIV_NUM_W'(prod_q) + DIV_NUM_W'(q1_q)),
    .divisor_i  ({q1_q, 1'b0}),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Tile probe: the write/viewer tile when idle, the walk position otherwise.
  coord_t            pr, pc;
  logic              probe_ok;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    if (state_q == ST_IDLE) begin
      pr = coord_t'({4'b0000, pl.row_a});
      pc = coord_t'({4'b0000, pl.col_a});
    end else begin
      pr = coord_t'({4'b0000, cr_q}) + scale(ru_q, V_W'(u_q)) + scale(rv_q, v_q);
      pc = coord_t'({4'b0000, cc_q}) + scale(cu_q, V_W'(u_q)) + scale(cv_q, v_q);
    end
    probe_ok = !pr[COORD_W-1] && !pc[COORD_W-1]
               && (pr < coord_t'(MAP_ROWS)) && (pc < coord_t'(MAP_COLS));
    rd_addr  = ADDR_W'(int'(pr[COORD_W-2:0]) * MAP_COLS + int'(pc[COORD_W-2:0]));
  end

  logic                    we;
  logic [ADDR_W-1:0]       wr_addr;
  logic [TERRAIN_BITS-1:0] wr_data;

  always_comb begin
    we      = 1'b0;
    wr_addr = rd_addr;
    wr_data = TERRAIN_BITS'(pl.terrain_bits);
    if (state_q == ST_CLEAR) begin
      we      = 1'b1;
      wr_addr = clr_q;
      wr_data = '0;
    end else if (in_fire && pl.action == ACT_WRITE && probe_ok) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
    ok_q    <= probe_ok;
  end

  logic tile_pass, cmp_break, end_fail, last_col;

  assign tile_pass = ok_q && ((32'(rdata_q) & 32'(pm_q)) != 32'd0);
  assign cmp_break = prod_q >= mul_y;
  assign end_fail  = !space_q || (prod_q > mul_y);
  assign last_col  = (7'(u_q) + 7'd1) == 7'(maxd_q);

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    case (state_q)
      ST_CLEAR: if (clr_q == ADDR_W'(MAP_DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_fire && pl.action == ACT_QUERY) begin
          if (same_in) begin
            state_d = ST_DONE;
            res_d   = 1'b1;
          end else if (far_in) begin
            state_d = ST_DONE;
            res_d   = 1'b0;
          end else begin
            state_d = ST_VCHK;
          end
        end
      end
      ST_VCHK: begin
        if (!tile_pass) begin
          state_d = ST_DONE;
          res_d   = 1'b0;
        end else if (su_maxd <= 6'd1) begin
          state_d = ST_DONE;
          res_d   = 1'b1;
        end else begin
          state_d = ST_MUL0;
        end
      end
      ST_MUL0: state_d = ST_DIVS;
      ST_DIVS: state_d = ST_DIVW;
      ST_DIVW: if (div_done) state_d = ST_RD;
      ST_RD:   state_d = ST_TILE;
      ST_TILE: state_d = (!tile_pass && space_q) ? ST_ENDA : ST_CMPA;
      ST_CMPA: state_d = ST_CMPB;
      ST_CMPB: state_d = cmp_break ? ST_ENDA : ST_RD;
      ST_ENDA: state_d = ST_ENDB;
      ST_ENDB: begin
        if (end_fail) begin
          state_d = ST_DONE;
          res_d   = 1'b0;
        end else if (last_col) begin
          state_d = ST_DONE;
          res_d   = 1'b1;
        end else begin
          state_d = ST_MUL0;
        end
      end
      ST_DONE: if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign load_out = (in_fire && pl.action == ACT_WRITE)
                    || (state_q == ST_DONE && (!out_valid_q || out_o.ready));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
      res_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.is_query_result <= (state_q == ST_DONE);
      out_q.line_clear      <= (state_q == ST_DONE) && res_q;
    end
    if (in_fire) begin
      cr_q  <= pl.row_a;
      cc_q  <= pl.col_a;
      pm_q  <= pl.pass_mask;
      adr_q <= adr_in;
      adc_q <= adc_in;
      drn_q <= dr_in[6];
      dcn_q <= dc_in[6];
    end
    case (state_q)
      ST_VCHK: begin
        maxd_q <= su_maxd;
        p1_q   <= su_p1;
        q1_q   <= su_q1;
        p2_q   <= su_p2;
        q2_q   <= su_q2;
        ru_q   <= su_dr_m;
        cu_q   <= su_dc_m;
        rv_q   <= -sign_mul(su_or, su_dc_m);
        cv_q   <= sign_mul(su_or, su_dr_m);
        u_q    <= 6'd1;
      end
      ST_MUL0: prod_q <= mul_y;
      ST_DIVS: begin
        space_q <= 1'b0;
        block_q <= 1'b0;
      end
      ST_DIVW: if (div_done) v_q <= div_quo[V_W-1:0];
      ST_TILE: begin
        if (tile_pass) begin
          if (!space_q) begin
            // First open tile after a wall raises the lower slope bound.
            if (block_q) begin
              p1_q <= P_W'({v_q, 1'b0} - 9'd1);
              q1_q <= two_u_m1;
            end
            space_q <= 1'b1;
          end
        end else if (space_q) begin
          // A wall after open tiles lowers the upper slope bound.
          p2_q <= P_W'({v_q, 1'b0} - 9'd1);
          q2_q <= two_u_p1;
        end else begin
          block_q <= 1'b1;
        end
      end
      ST_CMPA: prod_q <= mul_y;
      ST_CMPB: if (!cmp_break) v_q <= v_q + 1'b1;
      ST_ENDA: prod_q <= mul_y;
      ST_ENDB: if (!end_fail && !last_col) u_q <= u_q + 1'b1;
      default: ;
    endcase
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state is not one-hot");

  a_div_only_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIVW)
    else $error("divider finished outside its wait state");

  a_no_take_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while result register is blocked");

  a_clear_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && clr_q == ADDR_W'(MAP_DEPTH - 1)) |=> state_q == ST_IDLE)
    else $error("clearing sweep did not end in idle");

endmodule

`default_nettype wire

// ===== test/glc_checker.sv =====
// Checker for the grid line-of-sight block: keeps a copy of the terrain grid,
// predicts one result word per request word and compares. Depends on glc_pkg, glc_ifs.
module glc_checker import glc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  glc_in_if         in_w,
  glc_out_if        out_w,
  output int        fail_count_o,
  output int        pending_o
);

  logic [TERRAIN_BITS-1:0] grid_copy [MAP_DEPTH];
  glc_out_t                answers_due [$];

  function automatic bit tile_clear(int r, int c, int pm);
    if (r < 0 || c < 0 || r >= MAP_ROWS || c >= MAP_COLS) return 0;
    return (int'(grid_copy[r * MAP_COLS + c]) & pm) != 0;
  endfunction

  // Octant walk with a narrowing rational slope interval [p1/q1, p2/q2].
  function automatic bit sight_clear(int cr, int cc, int rad, int pm, int tr, int tc);
    int dr, dc, adr, adc, orient, maxd, mind;
    int p1, q1, p2, q2, u, v, r, c;
    bit space, blocked, done;
    if (cr == tr && cc == tc) return 1;
    if (cr - tr > rad || tr - cr > rad || cc - tc > rad || tc - cc > rad) return 0;
    if (!tile_clear(cr, cc, pm)) return 0;
    adr = tr - cr;
    adc = tc - cc;
    dr = 1;
    dc = 1;
    if (adr < 0) begin adr = -adr; dr = -1; end
    if (adc < 0) begin adc = -adc; dc = -1; end
    if (adr == adc) begin
      p1 = 1; q1 = 1; p2 = 1; q2 = 1;
      if (dr == dc) dc = 0;
      else dr = 0;
      orient = 1;
      maxd = adr;
      mind = adr;
    end else begin
      if (adr > adc) begin
        orient = dr * dc;
        dc = 0;
        maxd = adr;
        mind = adc;
      end else begin
        orient = -dr * dc;
        dr = 0;
        maxd = adc;
        mind = adr;
      end
      if (mind == 0) begin
        p1 = 0; q1 = 1; p2 = 0; q2 = 1;
      end else begin
        p1 = 2 * mind - 1;
        q1 = 2 * maxd + 1;
        p2 = 2 * mind + 1;
        q2 = 2 * maxd - 1;
      end
    end
    for (u = 1; u <= maxd - 1; u++) begin
      v = (p1 * (2 * u - 1) + q1) / (2 * q1);
      r = cr + dr * u - orient * dc * v;
      c = cc + dc * u + orient * dr * v;
      space = 0;
      blocked = 0;
      done = 0;
      while (!done) begin
        if (tile_clear(r, c, pm)) begin
          if (!space) begin
            if (blocked) begin
              p1 = 2 * v - 1;
              q1 = 2 * u - 1;
            end
            space = 1;
          end
        end else begin
          if (space) begin
            p2 = 2 * v - 1;
            q2 = 2 * u + 1;
            done = 1;
          end
          blocked = 1;
        end
        if (!done) begin
          if ((2 * v + 1) * q2 >= p2 * (2 * u + 1)) done = 1;
          else begin
            r -= orient * dc;
            c += orient * dr;
            v++;
          end
        end
      end
      if (!space || p1 * q2 > p2 * q1) return 0;
    end
    return 1;
  endfunction

  task automatic report(string what, glc_out_t got, glc_out_t want);
    $display("mismatch %s: got query=%0b clear=%0b, want query=%0b clear=%0b",
             what, got.is_query_result, got.line_clear,
             want.is_query_result, want.line_clear);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    glc_out_t want, got;
    glc_in_t  w;
    if (!rst_ni) begin
      for (int i = 0; i < MAP_DEPTH; i++) grid_copy[i] = '0;
      answers_due.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_w.valid && out_w.ready) begin
        got = out_w.payload;
        if (answers_due.size() == 0) begin
          report("unexpected word", got, '0);
        end else begin
          want = answers_due.pop_front();
          if (got.is_query_result !== want.is_query_result)
            report("is_query_result", got, want);
          else if (got.line_clear !== want.line_clear)
            report("line_clear", got, want);
        end
      end
      if (in_w.valid && in_w.ready) begin
        w = in_w.payload;
        if (w.action == ACT_WRITE) begin
          grid_copy[{w.row_a, w.col_a}] = w.terrain_bits;
          want = '{is_query_result: 1'b0, line_clear: 1'b0};
        end else begin
          want.is_query_result = 1'b1;
          want.line_clear = sight_clear(w.row_a, w.col_a, w.sight_radius,
                                        w.pass_mask, w.target_row, w.target_col);
        end
        answers_due.push_back(want);
      end
      pending_o = answers_due.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// Top of the line-of-sight testbench: clock, reset, stimulus, receiver stalls,
// watchdog and verdict. Depends on glc_pkg, glc_ifs, glc_checker and the block.
module testbench import glc_pkg::*;;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, idle_cycles, burst_left;
  int   win_r, win_c;
  bit   rx_eager;

  glc_in_if  in_w ();
  glc_out_if out_w ();

  grid_line_of_sight_check DUT (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_w), .out_o(out_w));

  glc_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_w(in_w), .out_w(out_w),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_w.valid = 1'b0;
    in_w.payload = '0;
    out_w.ready = 1'b0;
  end

  // Receiver: phases of always-ready alternate with phases of random stalls.
  always @(posedge clk_i) begin
    if ($urandom_range(0, 99) == 0) rx_eager <= ~rx_eager;
    if (rx_eager) out_w.ready <= 1'b1;
    else out_w.ready <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk_i) begin
    if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 40000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_word(glc_in_t w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_w.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_w.valid <= 1'b1;
    in_w.payload <= w;
    do @(posedge clk_i); while (!in_w.ready);
  endtask

  task automatic write_tile(int r, int c, logic [15:0] bits);
    glc_in_t w;
    w = glc_in_t'($bits(glc_in_t)'({$urandom, $urandom}));
    w.action = ACT_WRITE;
    w.row_a = 6'(r);
    w.col_a = 6'(c);
    w.terrain_bits = bits;
    send_word(w);
  endtask

  task automatic ask_sight(int vr, int vc, int tr, int tc, int rad, logic [15:0] pm);
    glc_in_t w;
    w = glc_in_t'($bits(glc_in_t)'({$urandom, $urandom}));
    w.action = ACT_QUERY;
    w.row_a = 6'(vr);
    w.col_a = 6'(vc);
    w.target_row = 6'(tr);
    w.target_col = 6'(tc);
    w.sight_radius = 6'(rad);
    w.pass_mask = pm;
    send_word(w);
  endtask

  function automatic logic [15:0] pick_terrain();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0001 << $urandom_range(0, 15);
      default: return 16'h0001 | 16'($urandom);
    endcase
  endfunction

  function automatic int near(int base);
    int x;
    x = base + $urandom_range(0, 13);
    return (x > 63) ? 63 : x;
  endfunction

  task automatic pause_until_drained();
    in_w.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int rad, vr, vc;
    rx_eager = 1'b0;
    burst_left = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: grid extremes, same tile, range limit, blocked viewer.
    write_tile(0, 0, 16'hFFFF);
    write_tile(63, 63, 16'hFFFF);
    write_tile(0, 63, 16'h8000);
    write_tile(63, 0, 16'h0000);
    for (int i = 1; i < 6; i++) write_tile(i, i, 16'h0001);
    ask_sight(63, 0, 63, 0, 0, 16'h0000);
    ask_sight(0, 0, 0, 5, 4, 16'hFFFF);
    ask_sight(63, 0, 62, 1, 63, 16'hFFFF);
    ask_sight(0, 0, 6, 6, 63, 16'h0001);
    ask_sight(0, 0, 63, 63, 63, 16'hFFFF);
    ask_sight(0, 63, 0, 0, 63, 16'h8000);
    ask_sight(0, 0, 1, 0, 1, 16'h0002);
    ask_sight(63, 63, 0, 0, 63, 16'h0001);
    ask_sight(0, 0, 2, 1, 63, 16'hFFFF);
    pause_until_drained();

    // Random part: most words land in a small window so masks and queries meet.
    for (int n = 0; n < 400; n++) begin
      if (n % 60 == 0) begin
        win_r = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 63);
        win_c = ($urandom_range(0, 3) == 0) ? 50 : $urandom_range(0, 63);
      end
      if (n == 200) pause_until_drained();
      if ($urandom_range(0, 9) < 5) begin
        if ($urandom_range(0, 9) == 0)
          write_tile($urandom_range(0, 63), $urandom_range(0, 63), 16'($urandom));
        else
          write_tile(near(win_r), near(win_c), pick_terrain());
      end else begin
        rad = ($urandom_range(0, 29) == 0) ? 63 : $urandom_range(0, 14);
        vr = near(win_r);
        vc = near(win_c);
        if ($urandom_range(0, 9) == 0)
          ask_sight($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 63), $urandom_range(0, 63), 16'($urandom));
        else
          ask_sight(vr, vc, near(win_r), near(win_c), rad,
                    ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'h0001);
      end
    end

    in_w.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
src/glc_pkg.sv
src/glc_ifs.sv
src/glc_div.sv
src/grid_line_of_sight_check.sv
test/glc_checker.sv
test/testbench.sv
